FILE: rtl/float_image_to_byte_normalizer_assert.svh
// Assertion helpers used by the checker file.
`ifndef FLOAT_IMAGE_TO_BYTE_NORMALIZER_ASSERT_SVH
`define FLOAT_IMAGE_TO_BYTE_NORMALIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define FIBN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define FIBN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fibn_pkg.sv
package fibn_pkg;

    // Frame size limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Field widths
    localparam int SAMPLE_W   = 32;
    localparam int PIXEL_W    = 8;
    localparam int SIZE_W     = 13;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Raster counter widths and compare width
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMP_A = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W = ((CMP_A > SIZE_W) ? CMP_A : SIZE_W) + 1;

    // Range, reciprocal and divider sizing
    localparam int RANGE_W    = 32;
    localparam int RECIP_W    = 40;
    localparam int RECIP_HI_W = RECIP_W - RANGE_W;
    localparam int DIV_CNT_W  = $clog2(RECIP_W);
    localparam logic [RECIP_W-1:0] DIVIDEND = RECIP_W'(255) << RANGE_W;
    localparam logic [PIXEL_W-1:0] PIX_MAX  = 8'hFF;

    // Rounded product width before the clamp
    localparam int X_W = RECIP_HI_W + RANGE_W + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAP_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_BORDER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

    // Map modes
    localparam logic [MODE_W-1:0] MODE_MAX    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MINMAX = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;

    // Item actions
    localparam logic ACT_STAT = 1'b0;
    localparam logic ACT_MAP  = 1'b1;

    // Controller states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIFF  = 6'b000010,
        ST_MULT  = 6'b000100,
        ST_SUM   = 6'b001000,
        ST_LATCH = 6'b010000,
        ST_DIV   = 6'b100000
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic latch;
        logic div_step;
        logic diff;
        logic mult;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic item_map;
        logic item_last;
        logic range_zero;
        logic div_last;
        logic out_stall;
    } dp_status_t;

endpackage

FILE: rtl/fibn_in_if.sv
interface fibn_in_if
    import fibn_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       finite;

    modport source (output valid, action, sample, finite, input ready);
    modport sink   (input valid, action, sample, finite, output ready);
endinterface

FILE: rtl/fibn_out_if.sv
interface fibn_out_if
    import fibn_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               frame_end;

    modport source (output valid, pixel, frame_end, input ready);
    modport sink   (input valid, pixel, frame_end, output ready);
endinterface

FILE: rtl/float_image_to_byte_normalizer.sv
// Normalizer (max, min-max or auto mode) of signed Q16.16 frames to bytes.
// Each frame is sent twice in raster order: statistics items (action 0) give
// no result; mapping items (action 1) give one byte each and pass through the
// capture, subtract, multiply and round states.
// The last statistics item of a frame is followed by a state that picks the
// range and then the bit-serial divider that forms the reciprocal
// 255 * 2^32 / range, with the input held off. A frame that maps to black
// skips the divider and holds the input off only for the range pick. A result
// waits in an output register, so the next item is accepted while it is still
// pending; a stalled output holds the next mapping item in its rounding stage.
module float_image_to_byte_normalizer
    import fibn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    fibn_in_if.sink               sample_in,
    fibn_out_if.source            pixel_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    fibn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (sample_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    fibn_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_action (sample_in.action),
        .in_sample (sample_in.sample),
        .in_finite (sample_in.finite),
        .cmd       (cmd),
        .status    (status),
        .out_valid (pixel_out.valid),
        .out_ready (pixel_out.ready),
        .pixel     (pixel_out.pixel),
        .frame_end (pixel_out.frame_end)
    );

endmodule

FILE: rtl/fibn_div.sv
module fibn_div
    import fibn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               step,
    input  logic [RANGE_W-1:0] divisor,
    output logic [RECIP_W-1:0] quotient,
    output logic               last
);

    logic [RANGE_W-1:0]   div_reg;
    logic [RANGE_W-1:0]   rem_reg;
    logic [RANGE_W-1:0]   rem_next;
    logic [RECIP_W-1:0]   quo_reg;
    logic [RECIP_W-1:0]   quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [RANGE_W:0]     trial;
    logic [RANGE_W:0]     diff;
    logic                 fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[RECIP_W-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? diff[RANGE_W-1:0] : trial[RANGE_W-1:0];
        quo_next = {quo_reg[RECIP_W-2:0], fits};
        cnt_next = cnt_reg + DIV_CNT_W'(1);
    end

    // Hold the step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Advance remainder and quotient
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= DIVIDEND;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == DIV_CNT_W'(RECIP_W - 1));

endmodule

FILE: rtl/fibn_ctrl.sv
module fibn_ctrl
    import fibn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Sequence the datapath for each item
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid)
                begin
                    if (status.item_map)
                    begin
                        state_next = ST_DIFF;
                    end
                    else if (status.item_last)
                    begin
                        state_next = ST_LATCH;
                    end
                end
            end
            ST_LATCH:
            begin
                cmd.latch  = 1'b1;
                state_next = status.range_zero ? ST_IDLE : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (!status.out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/fibn_dp.sv
module fibn_dp
    import fibn_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_action,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  logic                       in_finite,
    input  ctrl_cmd_t                  cmd,
    output dp_status_t                 status,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [PIXEL_W-1:0]         pixel,
    output logic                       frame_end
);

    // Configuration
    logic [MODE_W-1:0] mode_reg;
    logic              skip_reg;
    logic [SIZE_W-1:0] fw_reg;
    logic [SIZE_W-1:0] fh_reg;

    // Raster position
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;

    // Statistics
    logic signed [SAMPLE_W-1:0] rmin_reg;
    logic signed [SAMPLE_W-1:0] rmax_reg;
    logic signed [SAMPLE_W-1:0] wmin_reg;
    logic                       rseen_reg;
    logic                       wseen_reg;

    // Latched mapping
    logic signed [SAMPLE_W-1:0] base_reg;
    logic [RANGE_W-1:0]         range_reg;
    logic                       black_reg;

    // Item and mapping stages
    logic signed [SAMPLE_W-1:0] v_reg;
    logic                       fin_reg;
    logic                       last_reg;
    logic [RANGE_W-1:0]         d_reg;
    logic                       zero_reg;
    logic                       sat_reg;
    logic [2*RANGE_W-1:0]       plo_reg;
    logic [RECIP_W-1:0]         phi_reg;

    // Output register
    logic                       ov_reg;
    logic                       ov_next;
    logic [PIXEL_W-1:0]         pix_reg;
    logic [PIXEL_W-1:0]         pix_next;
    logic                       end_reg;

    // Combinational helpers
    logic [SIZE_W-1:0]   w_eff;
    logic [SIZE_W-1:0]   h_eff;
    logic [CMP_W-1:0]    col_x;
    logic [CMP_W-1:0]    row_x;
    logic [CMP_W-1:0]    w_x;
    logic [CMP_W-1:0]    h_x;
    logic                row_end;
    logic                last;
    logic                in_region;
    logic                use_mm;
    logic                range_zero;
    logic [SAMPLE_W:0]   span;
    logic [RANGE_W-1:0]  range_sel;
    logic signed [SAMPLE_W-1:0] base_sel;
    logic signed [SAMPLE_W:0]   d_full;
    logic                d_pos;
    logic [RECIP_W-1:0]  recip;
    logic                div_last;
    logic [2*RANGE_W:0]  rnd;
    logic [X_W-1:0]      x_sum;

    fibn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.latch && !range_zero),
        .step     (cmd.div_step),
        .divisor  (range_sel),
        .quotient (recip),
        .last     (div_last)
    );

    // Clamp frame sizes and find the raster position flags
    always_comb
    begin
        if (fw_reg == '0)
        begin
            w_eff = SIZE_W'(1);
        end
        else if (fw_reg > MAX_WIDTH)
        begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = fw_reg;
        end
        if (fh_reg == '0)
        begin
            h_eff = SIZE_W'(1);
        end
        else if (fh_reg > MAX_HEIGHT)
        begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = fh_reg;
        end
        col_x   = CMP_W'(col_reg);
        row_x   = CMP_W'(row_reg);
        w_x     = CMP_W'(w_eff);
        h_x     = CMP_W'(h_eff);
        row_end = (col_x + CMP_W'(1)) >= w_x;
        last    = row_end && ((row_x + CMP_W'(1)) >= h_x);
        in_region = 1'b1;
        if (skip_reg && (w_x >= CMP_W'(3)) && (h_x >= CMP_W'(3)))
        begin
            in_region = (col_x >= CMP_W'(1)) && ((col_x + CMP_W'(1)) < w_x) &&
                        (row_x >= CMP_W'(1)) && ((row_x + CMP_W'(1)) < h_x);
        end
        col_next = row_end ? '0 : col_reg + COL_W'(1);
        if (!row_end)
        begin
            row_next = row_reg;
        end
        else if (last)
        begin
            row_next = '0;
        end
        else
        begin
            row_next = row_reg + ROW_W'(1);
        end
    end

    // Choose the mapping from the gathered statistics
    always_comb
    begin
        if (mode_reg == MODE_MAX)
        begin
            use_mm = 1'b0;
        end
        else if (mode_reg == MODE_MINMAX)
        begin
            use_mm = 1'b1;
        end
        else
        begin
            use_mm = wseen_reg && (wmin_reg < 0);
        end
        span = {rmax_reg[SAMPLE_W-1], rmax_reg} - {rmin_reg[SAMPLE_W-1], rmin_reg};
        if (use_mm)
        begin
            range_zero = !(rseen_reg && (rmax_reg > rmin_reg));
            range_sel  = span[RANGE_W-1:0];
            base_sel   = rmin_reg;
        end
        else
        begin
            range_zero = !(rseen_reg && (rmax_reg > 0));
            range_sel  = RANGE_W'(rmax_reg);
            base_sel   = '0;
        end
    end

    // Mapping arithmetic
    always_comb
    begin
        d_full   = {v_reg[SAMPLE_W-1], v_reg} - {base_reg[SAMPLE_W-1], base_reg};
        d_pos    = !d_full[SAMPLE_W] && (d_full != '0);
        rnd      = {1'b0, plo_reg} + ((2*RANGE_W+1)'(1) << (RANGE_W - 1));
        x_sum    = X_W'(phi_reg) + X_W'(rnd[2*RANGE_W:RANGE_W]);
        if (zero_reg)
        begin
            pix_next = '0;
        end
        else if (sat_reg || (x_sum > X_W'(PIX_MAX)))
        begin
            pix_next = PIX_MAX;
        end
        else
        begin
            pix_next = x_sum[PIXEL_W-1:0];
        end
        ov_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_AUTO;
            skip_reg <= 1'b1;
            fw_reg   <= SIZE_W'(640);
            fh_reg   <= SIZE_W'(480);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAP_MODE:     mode_reg <= cfg_data[MODE_W-1:0];
                REG_SKIP_BORDER:  skip_reg <= cfg_data[0];
                REG_FRAME_WIDTH:  fw_reg   <= cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: fh_reg   <= cfg_data[SIZE_W-1:0];
                default:          mode_reg <= mode_reg;
            endcase
        end
    end

    // Advance position, gather statistics, latch the mapping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            rmin_reg  <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            rmax_reg  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            wmin_reg  <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            rseen_reg <= 1'b0;
            wseen_reg <= 1'b0;
            base_reg  <= '0;
            range_reg <= '0;
            black_reg <= 1'b1;
        end
        else if (cmd.latch)
        begin
            base_reg  <= range_zero ? '0 : base_sel;
            range_reg <= range_sel;
            black_reg <= range_zero;
            rmin_reg  <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            rmax_reg  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            wmin_reg  <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            rseen_reg <= 1'b0;
            wseen_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if ((in_action == ACT_STAT) && in_finite)
            begin
                if (in_sample < wmin_reg)
                begin
                    wmin_reg <= in_sample;
                end
                wseen_reg <= 1'b1;
                if (in_region)
                begin
                    if (in_sample < rmin_reg)
                    begin
                        rmin_reg <= in_sample;
                    end
                    if (in_sample > rmax_reg)
                    begin
                        rmax_reg <= in_sample;
                    end
                    rseen_reg <= 1'b1;
                end
            end
        end
    end

    // Capture the item and run the mapping stages
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            v_reg    <= in_sample;
            fin_reg  <= in_finite;
            last_reg <= last;
        end
        if (cmd.diff)
        begin
            d_reg    <= d_full[RANGE_W-1:0];
            zero_reg <= !fin_reg || black_reg || !d_pos;
            sat_reg  <= d_full[RANGE_W-1:0] >= range_reg;
        end
        if (cmd.mult)
        begin
            plo_reg <= d_reg * recip[RANGE_W-1:0];
            phi_reg <= RECIP_W'(d_reg) * RECIP_W'(recip[RECIP_W-1:RANGE_W]);
        end
        if (cmd.emit)
        begin
            pix_reg <= pix_next;
            end_reg <= last_reg;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
        end
    end

    assign status.item_map   = (in_action == ACT_MAP);
    assign status.item_last  = last;
    assign status.range_zero = range_zero;
    assign status.div_last   = div_last;
    assign status.out_stall  = ov_reg && !out_ready;

    assign out_valid = ov_reg;
    assign pixel     = pix_reg;
    assign frame_end = end_reg;

endmodule

FILE: rtl/fibn_checker.sv
`include "float_image_to_byte_normalizer_assert.svh"

module fibn_checker
    import fibn_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               in_action,
    input logic               out_valid,
    input logic               out_ready,
    input logic [PIXEL_W-1:0] pixel,
    input logic               frame_end
);

    // A pending result stays offered
    `FIBN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
    // A pending result keeps its payload
    `FIBN_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(pixel) && $stable(frame_end), "result changed while stalled")
    // A mapping item occupies the datapath after it is taken
    `FIBN_ASSERT_NEXT(a_map_busy, clk, rst_n, in_valid && in_ready && (in_action == ACT_MAP), !in_ready, "input taken during mapping")
    // A new result only comes out of the mapping stages
    `FIBN_ASSERT_NOW(a_out_source, clk, rst_n, $rose(out_valid), $past(!in_ready), "result without mapping work")

endmodule

bind float_image_to_byte_normalizer fibn_checker u_fibn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .in_action (sample_in.action),
    .out_valid (pixel_out.valid),
    .out_ready (pixel_out.ready),
    .pixel     (pixel_out.pixel),
    .frame_end (pixel_out.frame_end)
);
